FILE: rtl/chm3_pkg.sv
// Shared types, constants and power tables for the 3x3 contraharmonic mean filter.
// No dependencies; every rtl module but chm3_checker refers to it by scoped names.
`default_nettype none
package chm3_pkg;

	localparam int NUM_W = 32;	// sum of nine 28-bit table values
	localparam int DEN_W = 29;	// sum of nine 25-bit table values
	localparam int ROM_W = 28;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Q_SELECT = 2'd2;

	// table selectors
	localparam int SEL_P25 = 0;
	localparam int SEL_P15 = 1;
	localparam int SEL_N05 = 2;
	localparam int SEL_N15 = 3;

	typedef logic [ROM_W-1:0] rom_t [256];

	typedef struct packed {
		logic wr;	// beat carries a pixel to store
		logic emit;	// beat produces a result
		logic top;
		logic bot;
		logic left;
		logic right;
		logic last;
		logic q;	// 1: Q = -1.5
	} job_flags_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_WRITE,
		BK_READ,
		BK_DRAIN,
		BK_PREP,
		BK_DIV,
		BK_DONE
	} back_state_t;

	function automatic logic [63:0] isqrt64(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] v;
		v = x;
		r = 64'd0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 64'd0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// restoring long division, used only while the tables are built
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = 64'd0;
		r = 65'd0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// round(sqrt(x/4)) from floor(sqrt(x))
	function automatic logic [ROM_W-1:0] half_round(logic [63:0] x);
		logic [63:0] s;
		s = (isqrt64(x) + 64'd1) >> 1;
		return s[ROM_W-1:0];
	endfunction

	function automatic rom_t build_rom(int sel);
		rom_t t;
		logic [63:0] g;
		logic [63:0] g3;
		logic [63:0] g5;
		for (int i = 0; i < 256; i++) begin
			g = 64'(i);
			g3 = g * g * g;
			g5 = g3 * g * g;
			case (sel)
				SEL_P25: t[i] = half_round(g5 << 18);
				SEL_P15: t[i] = half_round(g3 << 18);
				SEL_N05: t[i] = (i == 0) ? '0 : half_round(udiv64(64'd1 << 50, g));
				default: t[i] = (i == 0) ? '0 : half_round(udiv64(64'd1 << 50, g3));
			endcase
		end
		return t;
	endfunction

	localparam rom_t ROM_P25 = build_rom(SEL_P25);
	localparam rom_t ROM_P15 = build_rom(SEL_P15);
	localparam rom_t ROM_N05 = build_rom(SEL_N05);
	localparam rom_t ROM_N15 = build_rom(SEL_N15);

endpackage
`default_nettype wire

FILE: rtl/contraharmonic_mean_filter_3x3_core.sv
// Top level of the 3x3 contraharmonic mean filter: config registers, front, queue, back.
// Depends on chm3_pkg, chm3_front, chm3_queue and chm3_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   in      | input     | in_valid / in_stall  | operation, pixel_in
//   out     | output    | out_valid / out_stall| pixel_out, frame_last
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Back steps: a beat that produces no result leaves the back part after the store step; one that
// produces a result goes through store, nine window reads from the single-port
// line memory, sum drain, divider setup, nine divider steps, output load.
// The front takes a beat every cycle while the two-entry job queue has room.
// Reset: asynchronous, clears control state; config goes to 512 x 512, Q = +1.5.
// No clearing pass: every window read hits a pixel written earlier in the same frame.
// Stalls: out_stall only holds the output register; the back keeps working on the
// next job and waits only when a new result is ready and the register is full and stalled.
`default_nettype none
module contraharmonic_mean_filter_3x3_core #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// pixel / flush beats
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic        operation,
	input  wire logic [7:0]  pixel_in,
	// filtered pixels
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [7:0]  pixel_out,
	output      logic        frame_last,
	// register writes
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [chm3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [chm3_pkg::CFG_DATA_W-1:0] cfg_data
);
	// ring holds two rows plus a few pixels of history
	localparam int RING_LEN = 2 * MAX_WIDTH + 4;
	localparam int AW = $clog2(RING_LEN);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int FW = $bits(chm3_pkg::job_flags_t);
	localparam int JW = FW + 8 + 2 * AW + WW;

	logic [10:0] frame_width_q;
	logic [12:0] frame_height_q;
	logic        q_select_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= 11'd512;
			frame_height_q <= 13'd512;
			q_select_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				chm3_pkg::REG_FRAME_WIDTH: frame_width_q <= cfg_data[10:0];
				chm3_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[12:0];
				chm3_pkg::REG_Q_SELECT: q_select_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front -> queue
	logic                 push, q_full, q_pop, q_not_empty;
	chm3_pkg::job_flags_t f_flags, b_flags;
	logic [7:0]           f_pixel, b_pixel;
	logic [AW-1:0]        f_wr_addr, f_ctr_addr, b_wr_addr, b_ctr_addr;
	logic [WW-1:0]        f_width, b_width;
	logic [JW-1:0]        q_in, q_head;

	chm3_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.RING_LEN(RING_LEN),
		.AW(AW),
		.WW(WW),
		.HW(HW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.frame_width(frame_width_q),
		.frame_height(frame_height_q),
		.q_select(q_select_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.pixel_in(pixel_in),
		.q_full(q_full),
		.push(push),
		.flags(f_flags),
		.pixel(f_pixel),
		.wr_addr(f_wr_addr),
		.ctr_addr(f_ctr_addr),
		.width(f_width)
	);

	assign q_in = {f_flags, f_pixel, f_wr_addr, f_ctr_addr, f_width};

	chm3_queue #(
		.WIDTH(JW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(q_in),
		.full(q_full),
		.pop(q_pop),
		.not_empty(q_not_empty),
		.head(q_head)
	);

	assign {b_flags, b_pixel, b_wr_addr, b_ctr_addr, b_width} = q_head;

	chm3_back #(
		.RING_LEN(RING_LEN),
		.AW(AW),
		.WW(WW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(q_not_empty),
		.job_pop(q_pop),
		.job_flags(b_flags),
		.job_pixel(b_pixel),
		.job_wr_addr(b_wr_addr),
		.job_ctr_addr(b_ctr_addr),
		.job_width(b_width),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_out(pixel_out),
		.frame_last(frame_last)
	);
endmodule
`default_nettype wire

FILE: rtl/chm3_queue.sv
// Small FIFO between the front and back parts of the filter.
// Depends on chm3_pkg for its depth.
`default_nettype none
module chm3_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output      logic             full,
	input  wire logic             pop,
	output      logic             not_empty,
	output      logic [WIDTH-1:0] head
);
	localparam int DEPTH = chm3_pkg::QUEUE_DEPTH;
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] ent_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			if (pop) rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (!push && pop) cnt_q <= cnt_q - CW'(1);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/chm3_front.sv
// Front part: takes input beats, tracks frame and output positions, builds jobs.
// Depends on chm3_pkg for the job flag struct.
`default_nettype none
module chm3_front #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 4096,
	parameter int RING_LEN = 2052,
	parameter int AW = 12,
	parameter int WW = 11,
	parameter int HW = 13
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [10:0]          frame_width,
	input  wire logic [12:0]          frame_height,
	input  wire logic                 q_select,
	input  wire logic                 in_valid,
	output      logic                 in_stall,
	input  wire logic                 operation,
	input  wire logic [7:0]           pixel_in,
	input  wire logic                 q_full,
	output      logic                 push,
	output      chm3_pkg::job_flags_t flags,
	output      logic [7:0]           pixel,
	output      logic [AW-1:0]        wr_addr,
	output      logic [AW-1:0]        ctr_addr,
	output      logic [WW-1:0]        width
);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = $clog2(MAX_WIDTH + 2);

	logic          open_q;
	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic          q_q;
	logic [RW-1:0] row_q, orow_q;
	logic [CW-1:0] col_q, ocol_q;
	logic [AW-1:0] wptr_q, optr_q;
	logic [PW-1:0] pend_q;

	logic          accept, is_pix, start, emit, emit_fl, last_in;
	logic [WW-1:0] e_w, cfg_w;
	logic [HW-1:0] e_h, cfg_h;
	logic          e_q;
	logic [RW-1:0] e_row, e_orow;
	logic [CW-1:0] e_col, e_ocol;
	logic [AW-1:0] e_wptr, e_optr;
	logic          o_bot, o_right;

	always_comb begin
		if (frame_width == '0) cfg_w = WW'(1);
		else if (32'(frame_width) > MAX_WIDTH) cfg_w = WW'(MAX_WIDTH);
		else cfg_w = WW'(frame_width);
		if (frame_height == '0) cfg_h = HW'(1);
		else if (32'(frame_height) > MAX_HEIGHT) cfg_h = HW'(MAX_HEIGHT);
		else cfg_h = HW'(frame_height);
	end

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;
	assign is_pix = !operation;
	assign start = is_pix && !open_q;

	// a new frame starts from fresh counters and latches the configured sizes and Q
	assign e_w = start ? cfg_w : w_q;
	assign e_h = start ? cfg_h : h_q;
	assign e_q = start ? q_select : q_q;
	assign e_row = start ? '0 : row_q;
	assign e_col = start ? '0 : col_q;
	assign e_orow = start ? '0 : orow_q;
	assign e_ocol = start ? '0 : ocol_q;
	assign e_wptr = start ? '0 : wptr_q;
	assign e_optr = start ? '0 : optr_q;

	assign last_in = (HW'(e_row) == e_h - HW'(1)) && (WW'(e_col) == e_w - WW'(1));
	assign emit_fl = !open_q && (pend_q != '0);
	assign emit = is_pix ? ((e_row >= RW'(2)) || ((e_row == RW'(1)) && (e_col != '0)))
		: emit_fl;
	assign push = accept && (is_pix || emit_fl);

	assign o_bot = (HW'(e_orow) == e_h - HW'(1));
	assign o_right = (WW'(e_ocol) == e_w - WW'(1));

	always_comb begin
		flags.wr = is_pix;
		flags.emit = emit;
		flags.top = (e_orow == '0);
		flags.bot = o_bot;
		flags.left = (e_ocol == '0);
		flags.right = o_right;
		flags.last = o_bot && o_right;
		flags.q = e_q;
	end
	assign pixel = pixel_in;
	assign wr_addr = e_wptr;
	assign ctr_addr = e_optr;
	assign width = e_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			w_q <= WW'(1);
			h_q <= HW'(1);
			q_q <= 1'b0;
			row_q <= '0;
			col_q <= '0;
			orow_q <= '0;
			ocol_q <= '0;
			wptr_q <= '0;
			optr_q <= '0;
			pend_q <= '0;
		end else if (accept) begin
			if (is_pix) begin
				w_q <= e_w;
				h_q <= e_h;
				q_q <= e_q;
				wptr_q <= (e_wptr == AW'(RING_LEN - 1)) ? '0 : e_wptr + AW'(1);
				if (last_in) begin
					open_q <= 1'b0;
					row_q <= '0;
					col_q <= '0;
					pend_q <= PW'(e_w) + PW'(e_h != HW'(1));
				end else begin
					open_q <= 1'b1;
					pend_q <= '0;
					if (WW'(e_col) == e_w - WW'(1)) begin
						col_q <= '0;
						row_q <= e_row + RW'(1);
					end else begin
						col_q <= e_col + CW'(1);
						row_q <= e_row;
					end
				end
			end else if (emit_fl) begin
				pend_q <= pend_q - PW'(1);
			end
			if (emit) begin
				optr_q <= (e_optr == AW'(RING_LEN - 1)) ? '0 : e_optr + AW'(1);
				if (o_right) begin
					ocol_q <= '0;
					orow_q <= e_orow + RW'(1);
				end else begin
					ocol_q <= e_ocol + CW'(1);
					orow_q <= e_orow;
				end
			end else if (is_pix) begin
				ocol_q <= e_ocol;
				orow_q <= e_orow;
				optr_q <= e_optr;
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/chm3_back.sv
// Back part: line memory, window walk with power tables, 9-step divider, output register.
// Depends on chm3_pkg for tables, job flags and the state type.
`default_nettype none
module chm3_back #(
	parameter int RING_LEN = 2052,
	parameter int AW = 12,
	parameter int WW = 11
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 job_valid,
	output      logic                 job_pop,
	input  wire chm3_pkg::job_flags_t job_flags,
	input  wire logic [7:0]           job_pixel,
	input  wire logic [AW-1:0]        job_wr_addr,
	input  wire logic [AW-1:0]        job_ctr_addr,
	input  wire logic [WW-1:0]        job_width,
	output      logic                 out_valid,
	input  wire logic                 out_stall,
	output      logic [7:0]           pixel_out,
	output      logic                 frame_last
);
	localparam int NW = chm3_pkg::NUM_W;
	localparam int DW = chm3_pkg::DEN_W;
	localparam int SW = DW + 8;
	localparam int XW = AW + 2;

	chm3_pkg::back_state_t state_q, state_d;

	logic [7:0]    mem [RING_LEN];
	logic [7:0]    rd_data_q;
	logic          acc_en_q;

	chm3_pkg::job_flags_t flags_q;
	logic [7:0]    pix_q;
	logic [AW-1:0] wr_addr_q, ctr_q;
	logic [WW-1:0] w_q;
	logic [1:0]    rk_q, ck_q;
	logic [NW-1:0] num_q, rem_q;
	logic [DW-1:0] den_q;
	logic          zero_q;
	logic [SW-1:0] dsh_q;
	logic [8:0]    quo_q;
	logic [3:0]    cnt_q;
	logic          out_valid_q;
	logic [7:0]    pix_out_q;
	logic          last_q;

	logic          load_out, mem_we, mem_re, ge, walk_end;
	logic [1:0]    rsel, csel;
	logic signed [XW-1:0] sum;
	logic [AW-1:0] raddr;
	logic [7:0]    result;

	// clamp window offsets at the frame borders: 0 is -1, 1 is 0, 2 is +1
	always_comb begin
		rsel = rk_q;
		if ((rk_q == 2'd0 && flags_q.top) || (rk_q == 2'd2 && flags_q.bot)) rsel = 2'd1;
		csel = ck_q;
		if ((ck_q == 2'd0 && flags_q.left) || (ck_q == 2'd2 && flags_q.right)) csel = 2'd1;
		sum = $signed({2'b00, ctr_q});
		if (rsel == 2'd0) sum = sum - $signed(XW'(w_q));
		else if (rsel == 2'd2) sum = sum + $signed(XW'(w_q));
		if (csel == 2'd0) sum = sum - $signed(XW'(1));
		else if (csel == 2'd2) sum = sum + $signed(XW'(1));
		if (sum < 0) raddr = AW'(sum + $signed(XW'(RING_LEN)));
		else if (sum >= $signed(XW'(RING_LEN))) raddr = AW'(sum - $signed(XW'(RING_LEN)));
		else raddr = AW'(sum);
	end

	assign walk_end = (rk_q == 2'd2) && (ck_q == 2'd2);
	assign ge = ({{(SW-NW){1'b0}}, rem_q} >= dsh_q);
	assign result = ((zero_q && flags_q.q) || den_q == '0) ? 8'd0
		: (quo_q[8] ? 8'd255 : quo_q[7:0]);

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		load_out = 1'b0;
		case (state_q)
			chm3_pkg::BK_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = chm3_pkg::BK_WRITE;
				end
			end
			chm3_pkg::BK_WRITE: begin
				mem_we = flags_q.wr;
				state_d = flags_q.emit ? chm3_pkg::BK_READ : chm3_pkg::BK_IDLE;
			end
			chm3_pkg::BK_READ: begin
				mem_re = 1'b1;
				if (walk_end) state_d = chm3_pkg::BK_DRAIN;
			end
			chm3_pkg::BK_DRAIN: state_d = chm3_pkg::BK_PREP;
			chm3_pkg::BK_PREP: state_d = chm3_pkg::BK_DIV;
			chm3_pkg::BK_DIV: begin
				if (cnt_q == 4'd0) state_d = chm3_pkg::BK_DONE;
			end
			chm3_pkg::BK_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d = chm3_pkg::BK_IDLE;
				end
			end
			default: state_d = chm3_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= chm3_pkg::BK_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr_q] <= pix_q;
		if (mem_re) rd_data_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			acc_en_q <= mem_re;
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			flags_q <= job_flags;
			pix_q <= job_pixel;
			wr_addr_q <= job_wr_addr;
			ctr_q <= job_ctr_addr;
			w_q <= job_width;
		end
		if (state_q == chm3_pkg::BK_WRITE) begin
			rk_q <= 2'd0;
			ck_q <= 2'd0;
			num_q <= '0;
			den_q <= '0;
			zero_q <= 1'b0;
		end
		if (state_q == chm3_pkg::BK_READ) begin
			if (ck_q == 2'd2) begin
				ck_q <= 2'd0;
				rk_q <= rk_q + 2'd1;
			end else begin
				ck_q <= ck_q + 2'd1;
			end
		end
		if (acc_en_q) begin
			if (flags_q.q) begin
				num_q <= num_q + NW'(chm3_pkg::ROM_N05[rd_data_q]);
				den_q <= den_q + DW'(chm3_pkg::ROM_N15[rd_data_q]);
				if (rd_data_q == 8'd0) zero_q <= 1'b1;
			end else begin
				num_q <= num_q + NW'(chm3_pkg::ROM_P25[rd_data_q]);
				den_q <= den_q + DW'(chm3_pkg::ROM_P15[rd_data_q]);
			end
		end
		if (state_q == chm3_pkg::BK_PREP) begin
			rem_q <= num_q;
			dsh_q <= {den_q, 8'd0};
			quo_q <= '0;
			cnt_q <= 4'd8;
		end
		if (state_q == chm3_pkg::BK_DIV) begin
			if (ge) rem_q <= rem_q - dsh_q[NW-1:0];
			quo_q <= {quo_q[7:0], ge};
			dsh_q <= dsh_q >> 1;
			cnt_q <= cnt_q - 4'd1;
		end
		if (load_out) begin
			pix_out_q <= result;
			last_q <= flags_q.last;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pix_out_q;
	assign frame_last = last_q;
endmodule
`default_nettype wire

FILE: rtl/chm3_checker.sv
// Port-level checks for the contraharmonic filter core, bound to the top level.
// Depends only on the top level's port names.
`default_nettype none
module chm3_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] pixel_out,
	input wire logic       frame_last,
	input wire logic       cfg_valid,
	input wire logic       cfg_ready
);
	logic seen_in_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seen_in_q <= 1'b0;
		else if (in_valid && !in_stall) seen_in_q <= 1'b1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixel_out) && $stable(frame_last))
		else $error("stalled result changed");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write refused");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_in_q)
		else $error("result before any input beat");
endmodule

bind contraharmonic_mean_filter_3x3_core chm3_checker u_chm3_checker (.*);
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for contraharmonic_mean_filter_3x3_core.
// Depends on chm3_pkg (register indexes) and the core RTL; predicts each result
// from its own power tables, line store and frame counters.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;
	localparam int LIMIT_W = 1024;
	localparam int LIMIT_H = 4096;
	localparam int RING = 2 * LIMIT_W + 4;
	localparam int SETTLE = 40;

	typedef struct {
		logic       op;
		logic [7:0] pix;
	} beat_t;

	typedef struct {
		logic [7:0] pix;
		logic       last;
	} filt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = OP_PIXEL;
	logic [7:0] pixel_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] pixel_out;
	logic frame_last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [chm3_pkg::CFG_IDX_W-1:0] cfg_index = chm3_pkg::REG_FRAME_WIDTH;
	logic [chm3_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	contraharmonic_mean_filter_3x3_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation), .pixel_in(pixel_in),
		.out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out),
		.frame_last(frame_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Filter predictor: power tables, line ring, frame position counters
	// ---------------------------------------------------------------------
	longint unsigned pow_p25[256], pow_p15[256], pow_n05[256], pow_n15[256];
	logic [7:0] ring_mem[RING];
	// raw register values as written
	logic [10:0] reg_w = 11'd512;
	logic [12:0] reg_h = 13'd512;
	logic        reg_q = 1'b0;
	// values latched at frame start
	int unsigned fr_w = 1, fr_h = 1;
	logic fr_q = 1'b0;
	int unsigned in_pos, out_row, out_col, drain_left;
	bit frame_busy = 0;

	filt_t expected_q[$];
	beat_t beats_q[$];
	int errors = 0;
	int checked = 0;
	int beats_sent = 0;
	int frames_run = 0;

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned r, c;
		r = 0;
		for (int b = 29; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (c * c <= x)
				r = c;
		end
		return r;
	endfunction

	function automatic longint unsigned rounded_half_sqrt(longint unsigned x);
		return (floor_sqrt(x) + 1) >> 1;
	endfunction

	task automatic build_power_tables();
		longint unsigned g, g3;
		for (int i = 0; i < 256; i++) begin
			g = i;
			g3 = g * g * g;
			pow_p25[i] = rounded_half_sqrt((g3 * g * g) << 18);
			pow_p15[i] = rounded_half_sqrt(g3 << 18);
			pow_n05[i] = (i == 0) ? 0 : rounded_half_sqrt((64'd1 << 50) / g);
			pow_n15[i] = (i == 0) ? 0 : rounded_half_sqrt((64'd1 << 50) / g3);
		end
	endtask

	function automatic int unsigned clamp_idx(int v, int unsigned n);
		if (v < 0)
			return 0;
		if (v >= int'(n))
			return n - 1;
		return v;
	endfunction

	// filtered value for the current output position, then advance it
	task automatic push_filtered();
		longint unsigned num, den, quo;
		bit has_zero;
		int unsigned rr, cc;
		logic [7:0] g;
		filt_t r;
		num = 0;
		den = 0;
		has_zero = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				rr = clamp_idx(int'(out_row) + dr, fr_h);
				cc = clamp_idx(int'(out_col) + dc, fr_w);
				g = ring_mem[(rr * fr_w + cc) % RING];
				if (!fr_q) begin
					num += pow_p25[g];
					den += pow_p15[g];
				end else begin
					num += pow_n05[g];
					den += pow_n15[g];
					if (g == 0)
						has_zero = 1;
				end
			end
		end
		if (has_zero || den == 0)
			quo = 0;
		else begin
			quo = num / den;
			if (quo > 255)
				quo = 255;
		end
		r.pix = quo[7:0];
		r.last = (out_row * fr_w + out_col == fr_w * fr_h - 1);
		expected_q.push_back(r);
		out_col++;
		if (out_col >= fr_w) begin
			out_col = 0;
			out_row++;
		end
	endtask

	task automatic predict_beat(beat_t b);
		int unsigned total;
		if (b.op == OP_FLUSH) begin
			if (!frame_busy && drain_left != 0) begin
				push_filtered();
				drain_left--;
			end
			return;
		end
		if (!frame_busy) begin
			fr_w = (reg_w == 0) ? 1 : (reg_w > LIMIT_W ? LIMIT_W : reg_w);
			fr_h = (reg_h == 0) ? 1 : (reg_h > LIMIT_H ? LIMIT_H : reg_h);
			fr_q = reg_q;
			in_pos = 0;
			out_row = 0;
			out_col = 0;
			drain_left = 0;	// leftovers of the old frame are dropped
			frame_busy = 1;
		end
		total = fr_w * fr_h;
		ring_mem[in_pos % RING] = b.pix;
		if (in_pos == total - 1) begin
			frame_busy = 0;
			drain_left = (total < fr_w + 1) ? total : fr_w + 1;
		end
		if (in_pos >= fr_w + 1)
			push_filtered();
		in_pos++;
	endtask

	// ---------------------------------------------------------------------
	// Input driver: presents beats from beats_q, random gap bursts
	// ---------------------------------------------------------------------
	bit idle_on = 1;
	int send_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		beat_t cur;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				cur.op = operation;
				cur.pix = pixel_in;
				predict_beat(cur);
				beats_sent++;
			end
			// payload may change only when nothing is held
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (beats_q.size() != 0) begin
					cur = beats_q.pop_front();
					in_valid <= 1'b1;
					operation <= cur.op;
					pixel_in <= cur.pix;
					if (idle_on && $urandom_range(0, 9) == 0)
						send_gap = $urandom_range(1, 8);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Output monitor: random stall bursts, one long hold-off on request
	// ---------------------------------------------------------------------
	int stall_left = 0;
	int holdoff_reqs = 0;
	int holdoff_seen = 0;

	always @(posedge clk or negedge arst_n) begin
		filt_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected beat pixel_out=%0d frame_last=%0b",
						$time, pixel_out, frame_last);
					errors++;
				end else begin
					want = expected_q.pop_front();
					checked++;
					if (pixel_out !== want.pix) begin
						$display("%0t: pixel_out expected %0d actual %0d",
							$time, want.pix, pixel_out);
						errors++;
					end
					if (frame_last !== want.last) begin
						$display("%0t: frame_last expected %0b actual %0b",
							$time, want.last, frame_last);
						errors++;
					end
				end
			end
			if (holdoff_seen != holdoff_reqs) begin
				holdoff_seen = holdoff_reqs;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 7);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	task automatic write_reg(logic [chm3_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
		bit ok;
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[chm3_pkg::CFG_DATA_W-1:0];
		forever begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
			if (ok)
				break;
		end
		cfg_valid <= 1'b0;
		case (idx)
			chm3_pkg::REG_FRAME_WIDTH: reg_w = val[10:0];
			chm3_pkg::REG_FRAME_HEIGHT: reg_h = val[12:0];
			default: reg_q = val[0];
		endcase
	endtask

	// block drained: nothing queued, nothing expected, back end settled
	task automatic wait_drained();
		while (beats_q.size() != 0 || in_valid || expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_frame(int unsigned w, int unsigned h, bit q);
		wait_drained();
		write_reg(chm3_pkg::REG_FRAME_WIDTH, w);
		write_reg(chm3_pkg::REG_FRAME_HEIGHT, h);
		write_reg(chm3_pkg::REG_Q_SELECT, q);
	endtask

	task automatic add_beat(logic op, logic [7:0] pix);
		beat_t b;
		b.op = op;
		b.pix = pix;
		beats_q.push_back(b);
	endtask

	task automatic add_flushes(int n);
		repeat (n) add_beat(OP_FLUSH, 8'($urandom));
	endtask

	function automatic logic [7:0] pick_pixel(int style);
		case (style)
			0: return 8'($urandom);
			1: return ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
				: 8'($urandom_range(90, 140));
			2: return ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 30));
			default: return 8'($urandom_range(200, 255));
		endcase
	endfunction

	logic [7:0] tail_px[7] = '{8'd0, 8'd128, 8'd1, 8'd0, 8'd255, 8'd255, 8'd0};
	int unsigned eff_w, eff_h, total_px, full_drain, nflush;
	bit drained_clean;
	int style;

	initial begin
		build_power_tables();
		for (int i = 0; i < RING; i++)
			ring_mem[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: 3x3 pepper case, zero in the window, flush while the frame is open
		set_frame(3, 3, 1'b0);
		add_beat(OP_PIXEL, 8'd0);
		add_beat(OP_PIXEL, 8'd255);
		add_beat(OP_FLUSH, 8'd0);	// frame still arriving: ignored
		foreach (tail_px[k])
			add_beat(OP_PIXEL, tail_px[k]);
		add_flushes(5);	// one more than pending: no result
		// salt filter, one zero forces 0
		set_frame(3, 3, 1'b1);
		for (int i = 0; i < 9; i++)
			add_beat(OP_PIXEL, (i == 4) ? 8'd0 : 8'(i * 30 + 10));
		add_flushes(4);
		// single pixel, all-zero window, zero width and height count as one
		set_frame(0, 0, 1'b0);
		add_beat(OP_PIXEL, 8'd0);
		add_flushes(2);
		// partial drain, then a new frame drops the leftovers
		set_frame(2, 2, 1'b1);
		for (int i = 0; i < 4; i++)
			add_beat(OP_PIXEL, 8'(255 - i));
		add_flushes(1);
		for (int i = 0; i < 4; i++)
			add_beat(OP_PIXEL, 8'(i + 1));
		add_flushes(3);

		set_frame(LIMIT_W, LIMIT_H, 1'b1);	// register maxima, no frame sent

		// long output hold-off while the sender keeps offering a full frame
		set_frame(16, 8, 1'b0);
		holdoff_reqs++;
		for (int i = 0; i < 128; i++)
			add_beat(OP_PIXEL, pick_pixel(0));
		add_flushes(17);

		// random frames, mostly well-formed with some noise and short drains
		drained_clean = 1;
		while (beats_sent + beats_q.size() < 1350) begin
			if (beats_sent + beats_q.size() > 1200)
				idle_on = 0;
			if (drained_clean && $urandom_range(0, 2) == 0)
				set_frame($urandom_range(0, 9) == 0 ? $urandom_range(1, 40) : $urandom_range(1, 8),
					$urandom_range(0, 9) == 0 ? $urandom_range(0, 12) : $urandom_range(1, 6),
					$urandom_range(0, 1));
			while (beats_q.size() > 64)
				@(posedge clk);
			eff_w = (reg_w == 0) ? 1 : reg_w;
			eff_h = (reg_h == 0) ? 1 : reg_h;
			total_px = eff_w * eff_h;
			full_drain = (total_px < eff_w + 1) ? total_px : eff_w + 1;
			style = $urandom_range(0, 3);
			for (int i = 0; i < total_px; i++) begin
				if ($urandom_range(0, 39) == 0)
					add_beat(OP_FLUSH, 8'($urandom));
				add_beat(OP_PIXEL, pick_pixel(style));
			end
			case ($urandom_range(0, 7))
				0: nflush = $urandom_range(0, full_drain);
				1: nflush = full_drain + $urandom_range(1, 3);
				default: nflush = full_drain;
			endcase
			add_flushes(nflush);
			drained_clean = (nflush >= full_drain);
			frames_run++;
		end

		wait_drained();
		$display("Covered %0d random frames plus directed frames, %0d beats in all;",
			frames_run, beats_sent);
		$display("%0d filtered pixels checked across both filter orders.", checked);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout: %0d results still expected", expected_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
